// ===== rtl/ckblit_pkg.sv =====
// Shared constants and types for the color keyed sprite blit unit.
`default_nettype none

package ckblit_pkg;

    // Largest sprite side and screen side the datapath handles
    localparam int MAX_SPRITE_SIDE = 1024;
    localparam int MAX_SCREEN_SIDE = 2048;

    // Counter and screen coordinate widths
    localparam int CNT_W = $clog2(MAX_SPRITE_SIDE);
    localparam int POS_W = $clog2(MAX_SCREEN_SIDE);

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_SPRITE_X      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SPRITE_Y      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SPRITE_WIDTH  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPRITE_HEIGHT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ROWS_TO_DRAW  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_WIDTH  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_HEIGHT = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_TRANSP_COLOR  = 3'd7;

    // One result item
    typedef struct packed {
        logic             write_enable;
        logic [POS_W-1:0] screen_col;
        logic [POS_W-1:0] screen_row;
        logic [15:0]      out_color;
        logic             last_pixel;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/color_keyed_sprite_blit_unit.sv =====
// Top level: color keyed sprite blitter with screen clipping and row limit.
//
// Usage:
//   Sprite pixels arrive on the s_axis channel (16-bit color in tdata), bottom
//   stored row first, left to right. Each pixel gives exactly one result on
//   m_axis: destination column, row and color in tdata, the write strobe in
//   tuser, and tlast on the sprite's final stored pixel, where the row and
//   column counters wrap to zero.
//   Throughput is one pixel per cycle while the receiver keeps up; the position
//   math, clip compares and key compare sit between the input handshake and one
//   result register. A skid register behind the result register lets one more
//   pixel transfer while the receiver stalls; s_axis_tready drops only once both
//   are full. Configuration goes through i_cfg_we / i_cfg_addr / i_cfg_data
//   while the stream is idle. Reset clears both counters, empties the output
//   stage and loads the register defaults (1x1 sprite at 0,0, 1024x768 screen,
//   all rows drawn, key color 0).
`default_nettype none

module color_keyed_sprite_blit_unit
    import ckblit_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [15:0]           i_cfg_data,
    // Pixel input
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [15:0]           s_axis_tdata,   // [15:0] pixel_color
    // Result output
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [39:0]                m_axis_tdata,   // [10:0] screen_col,
                                                       // [21:11] screen_row,
                                                       // [37:22] out_color, [39:38] 0
    output logic                       m_axis_tuser,   // [0] write_enable
    output logic                       m_axis_tlast    // last_pixel
);

    // Configuration registers
    logic [11:0] r_sprite_x;
    logic [11:0] r_sprite_y;
    logic [10:0] r_sprite_width;
    logic [10:0] r_sprite_height;
    logic [10:0] r_rows_to_draw;
    logic [11:0] r_screen_width;
    logic [11:0] r_screen_height;
    logic [15:0] r_transp_color;

    // Sprite walk counters
    logic [CNT_W-1:0] r_row_count, n_row_count;
    logic [CNT_W-1:0] r_col_count, n_col_count;

    // Output stage and skid stage
    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    logic    in_xfer;
    t_result res;

    // Per-pixel datapath signals
    logic [10:0]        spr_w, spr_h;
    logic [11:0]        scr_w, scr_h;
    logic signed [12:0] pos_x, pos_y;
    logic               on_screen;
    logic               row_end;
    logic               last;
    logic               we;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sprite_x      <= 12'd0;
            r_sprite_y      <= 12'd0;
            r_sprite_width  <= 11'd1;
            r_sprite_height <= 11'd1;
            r_rows_to_draw  <= 11'd1024;
            r_screen_width  <= 12'd1024;
            r_screen_height <= 12'd768;
            r_transp_color  <= 16'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SPRITE_X:      r_sprite_x      <= i_cfg_data[11:0];
                REG_SPRITE_Y:      r_sprite_y      <= i_cfg_data[11:0];
                REG_SPRITE_WIDTH:  r_sprite_width  <= i_cfg_data[10:0];
                REG_SPRITE_HEIGHT: r_sprite_height <= i_cfg_data[10:0];
                REG_ROWS_TO_DRAW:  r_rows_to_draw  <= i_cfg_data[10:0];
                REG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data[11:0];
                REG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[11:0];
                REG_TRANSP_COLOR:  r_transp_color  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp sizes: zero sprite side acts as one, oversize saturates
    always_comb begin
        if (r_sprite_width == 11'd0)
            spr_w = 11'd1;
        else if (r_sprite_width > 11'(MAX_SPRITE_SIDE))
            spr_w = 11'(MAX_SPRITE_SIDE);
        else
            spr_w = r_sprite_width;

        if (r_sprite_height == 11'd0)
            spr_h = 11'd1;
        else if (r_sprite_height > 11'(MAX_SPRITE_SIDE))
            spr_h = 11'(MAX_SPRITE_SIDE);
        else
            spr_h = r_sprite_height;

        scr_w = (r_screen_width > 12'(MAX_SCREEN_SIDE))
              ? 12'(MAX_SCREEN_SIDE) : r_screen_width;
        scr_h = (r_screen_height > 12'(MAX_SCREEN_SIDE))
              ? 12'(MAX_SCREEN_SIDE) : r_screen_height;
    end

    // Screen position, clipping and color key
    always_comb begin
        pos_x = $signed({r_sprite_x[11], r_sprite_x})
              + $signed({3'b000, r_col_count});
        pos_y = $signed({r_sprite_y[11], r_sprite_y})
              + $signed({2'b00, spr_h})
              - 13'sd1
              - $signed({3'b000, r_row_count});

        on_screen = !pos_x[12] && (pos_x[11:0] < scr_w)
                 && !pos_y[12] && (pos_y[11:0] < scr_h);
        we = on_screen
          && ({1'b0, r_row_count} < r_rows_to_draw)
          && (s_axis_tdata != r_transp_color);

        row_end = ({1'b0, r_col_count} + 11'd1) >= spr_w;
        last    = row_end && (({1'b0, r_row_count} + 11'd1) >= spr_h);

        res.write_enable = we;
        res.screen_col   = we ? pos_x[POS_W-1:0] : '0;
        res.screen_row   = we ? pos_y[POS_W-1:0] : '0;
        res.out_color    = s_axis_tdata;
        res.last_pixel   = last;
    end

    // Counter advance on each input transfer
    always_comb begin
        n_row_count = r_row_count;
        n_col_count = r_col_count;
        if (in_xfer) begin
            if (row_end) begin
                n_col_count = '0;
                n_row_count = last ? '0 : r_row_count + 1'b1;
            end else begin
                n_col_count = r_col_count + 1'b1;
            end
        end
    end

    // Output register with skid stage
    assign s_axis_tready = !r_skid_valid;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || m_axis_tready) begin
            // output slot frees up this cycle
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (in_xfer) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (in_xfer) begin
            // receiver stalled: park the new result
            n_skid       = res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count  <= '0;
            r_col_count  <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_row_count  <= n_row_count;
            r_col_count  <= n_col_count;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    // Result ports
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.out_color, r_out.screen_row, r_out.screen_col};
    assign m_axis_tuser  = r_out.write_enable;
    assign m_axis_tlast  = r_out.last_pixel;

endmodule

`default_nettype wire

// ===== test/color_keyed_sprite_blit_unit_tb.sv =====
// Self-checking testbench for the color keyed sprite blit unit: pixel stream, clipping, key.
`timescale 1ns / 1ps

import ckblit_pkg::*;

// Tracks the blitter's counters and registers and holds the screen writes still owed
class pixel_write_scoreboard;
    int spr_x, spr_y, spr_w, spr_h, rows_lim, scr_w, scr_h, key_color;
    int row_cnt, col_cnt;
    t_result pending_writes[$];
    int errors;

    function new();
        spr_x     = 0;
        spr_y     = 0;
        spr_w     = 1;
        spr_h     = 1;
        rows_lim  = 1024;
        scr_w     = 1024;
        scr_h     = 768;
        key_color = 0;
        row_cnt   = 0;
        col_cnt   = 0;
        errors    = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [15:0] data);
        case (idx)
            REG_SPRITE_X:      spr_x     = data[11:0];
            REG_SPRITE_Y:      spr_y     = data[11:0];
            REG_SPRITE_WIDTH:  spr_w     = data[10:0];
            REG_SPRITE_HEIGHT: spr_h     = data[10:0];
            REG_ROWS_TO_DRAW:  rows_lim  = data[10:0];
            REG_SCREEN_WIDTH:  scr_w     = data[11:0];
            REG_SCREEN_HEIGHT: scr_h     = data[11:0];
            REG_TRANSP_COLOR:  key_color = data;
            default: ;
        endcase
    endfunction

    function void flag(string msg);
        errors++;
        if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    // Accepted input pixel: work out its write and advance the counters
    function void note_pixel(logic [15:0] color);
        int w, h, sw, sh, sx, sy, px, py;
        bit row_end, final_px;
        t_result r;
        // zero sprite side acts as one, oversized sides saturate
        w  = (spr_w == 0) ? 1 : ((spr_w > MAX_SPRITE_SIDE) ? MAX_SPRITE_SIDE : spr_w);
        h  = (spr_h == 0) ? 1 : ((spr_h > MAX_SPRITE_SIDE) ? MAX_SPRITE_SIDE : spr_h);
        sw = (scr_w > MAX_SCREEN_SIDE) ? MAX_SCREEN_SIDE : scr_w;
        sh = (scr_h > MAX_SCREEN_SIDE) ? MAX_SCREEN_SIDE : scr_h;
        sx = (spr_x >= 2048) ? spr_x - 4096 : spr_x;
        sy = (spr_y >= 2048) ? spr_y - 4096 : spr_y;
        px = sx + col_cnt;
        // stored rows run bottom up
        py = sy + h - 1 - row_cnt;
        r = '0;
        r.write_enable = (px >= 0) && (px < sw) && (py >= 0) && (py < sh) &&
                         (row_cnt < rows_lim) && (color != key_color);
        if (r.write_enable) begin
            r.screen_col = px[POS_W-1:0];
            r.screen_row = py[POS_W-1:0];
        end
        r.out_color = color;
        row_end  = (col_cnt + 1 >= w);
        final_px = row_end && (row_cnt + 1 >= h);
        r.last_pixel = final_px;
        pending_writes.push_back(r);
        // counters wrap at end of row / sprite, also when a size shrank under them
        if (row_end) begin
            col_cnt = 0;
            row_cnt = final_px ? 0 : row_cnt + 1;
        end else begin
            col_cnt++;
        end
    endfunction

    // Output transfer: compare with the oldest owed write
    function void check_write(logic [39:0] data, logic user, logic last);
        t_result got, exp;
        got.write_enable = user;
        got.screen_col   = data[10:0];
        got.screen_row   = data[21:11];
        got.out_color    = data[37:22];
        got.last_pixel   = last;
        if (pending_writes.size() == 0) begin
            flag($sformatf("unexpected result we=%0b col=%0d row=%0d color=%h last=%0b",
                           got.write_enable, got.screen_col, got.screen_row,
                           got.out_color, got.last_pixel));
            return;
        end
        exp = pending_writes.pop_front();
        if (got !== exp) begin
            flag($sformatf({"mismatch: exp we=%0b col=%0d row=%0d color=%h last=%0b, ",
                            "got we=%0b col=%0d row=%0d color=%h last=%0b"},
                           exp.write_enable, exp.screen_col, exp.screen_row,
                           exp.out_color, exp.last_pixel,
                           got.write_enable, got.screen_col, got.screen_row,
                           got.out_color, got.last_pixel));
        end
    endfunction
endclass

module color_keyed_sprite_blit_unit_tb;

    // Cycles with no transfer or config write before the run is declared hung;
    // the longest quiet stretch is the receiver hold-off
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [15:0]           i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata  = '0;   // [15:0] pixel_color
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [39:0]           m_axis_tdata;         // [10:0] col, [21:11] row, [37:22] color
    logic                  m_axis_tuser;         // [0] write_enable
    logic                  m_axis_tlast;

    pixel_write_scoreboard sb;
    int idle_pct   = 37;
    bit hold_req   = 1'b0;
    int hold_left  = 0;
    int sent_count = 0;
    int stall_cycles = 0;

    int ext_pos[4]    = '{-2048, 2047, 0, -1};
    int ext_sprite[4] = '{0, 1, 1024, 2047};
    int ext_screen[4] = '{0, 1, 2048, 4095};

    color_keyed_sprite_blit_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random backpressure, or a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Check each output transfer
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_write(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            stall_cycles = 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("color_keyed_sprite_blit_unit test failed");
            $finish;
        end else begin
            stall_cycles++;
        end
    end

    // Register write; caller drops i_cfg_we after the last one
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    // One pixel transfer, with random idle cycles ahead of it
    task automatic send_pixel(input logic [15:0] color);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= color;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_pixel(color);
        sent_count++;
        @(negedge i_clk);
    endtask

    // Stop sending and wait for every owed result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_writes.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int phase, mode, n, x, y, w, h, rows, sw, sh;
        logic [15:0] key;
        sb = new();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset setting: 1x1 sprite at origin, key 0; every pixel ends the sprite
        hold_req = 1'b1;
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h8000);
        send_pixel(16'h0001);
        send_pixel(16'h5555);
        send_pixel(16'hAAAA);
        drain();

        // 3x3 sprite hanging off the left and bottom of a 4x3 screen: the bottom
        // stored row is skipped, the next one drawn, the top one cut by the row limit
        write_reg(REG_SPRITE_X, 16'hFFFF);
        write_reg(REG_SPRITE_Y, 16'd1);
        write_reg(REG_SPRITE_WIDTH, 16'd3);
        write_reg(REG_SPRITE_HEIGHT, 16'd3);
        write_reg(REG_ROWS_TO_DRAW, 16'd2);
        write_reg(REG_SCREEN_WIDTH, 16'd4);
        write_reg(REG_SCREEN_HEIGHT, 16'd3);
        write_reg(REG_TRANSP_COLOR, 16'h1234);
        i_cfg_we <= 1'b0;
        send_pixel(16'h0F0F);
        send_pixel(16'h1234);
        send_pixel(16'hF0F0);
        send_pixel(16'h7777);
        send_pixel(16'h1234);
        send_pixel(16'h0042);
        send_pixel(16'hBEEF);
        send_pixel(16'h1235);
        send_pixel(16'h1234);
        drain();

        // Zero sprite size acts as one, zero row limit draws nothing
        write_reg(REG_SPRITE_X, 16'd0);
        write_reg(REG_SPRITE_Y, 16'd0);
        write_reg(REG_SPRITE_WIDTH, 16'd0);
        write_reg(REG_SPRITE_HEIGHT, 16'd0);
        write_reg(REG_ROWS_TO_DRAW, 16'd0);
        i_cfg_we <= 1'b0;
        send_pixel(16'hCAFE);
        send_pixel(16'h0000);
        drain();
        // Zero screen width clips everything
        write_reg(REG_ROWS_TO_DRAW, 16'h07FF);
        write_reg(REG_SCREEN_WIDTH, 16'd0);
        i_cfg_we <= 1'b0;
        send_pixel(16'h1357);
        drain();
        // Oversized screen saturates; far corner is still on screen
        write_reg(REG_SCREEN_WIDTH, 16'h0FFF);
        write_reg(REG_SCREEN_HEIGHT, 16'h0FFF);
        write_reg(REG_SPRITE_X, 16'h07FF);
        write_reg(REG_SPRITE_Y, 16'h07FF);
        i_cfg_we <= 1'b0;
        send_pixel(16'h2468);
        drain();
        write_reg(REG_SPRITE_X, 16'h0800);
        i_cfg_we <= 1'b0;
        send_pixel(16'h9ABC);
        drain();

        // Random phases: new setting, a burst of pixels, then drain
        phase = 0;
        while (sent_count < 1420) begin
            idle_pct = (phase >= 8 && phase < 16) ? 0 : 37;
            mode = $urandom_range(9);
            key  = 16'($urandom);
            case (mode)
                0: begin
                    // raw 16-bit words, upper bits dropped by the block
                    x = $urandom; y = $urandom; w = $urandom; h = $urandom;
                    rows = $urandom; sw = $urandom; sh = $urandom;
                    n = $urandom_range(8, 60);
                end
                1: begin
                    x    = ext_pos[$urandom_range(3)];
                    y    = ext_pos[$urandom_range(3)];
                    w    = ext_sprite[$urandom_range(3)];
                    h    = ext_sprite[$urandom_range(3)];
                    rows = ext_sprite[$urandom_range(3)];
                    sw   = ext_screen[$urandom_range(3)];
                    sh   = ext_screen[$urandom_range(3)];
                    n = $urandom_range(8, 60);
                end
                default: begin
                    // small sprite near the edges of a small screen
                    sw   = $urandom_range(1, 24);
                    sh   = $urandom_range(1, 24);
                    w    = $urandom_range(1, 8);
                    h    = $urandom_range(1, 8);
                    x    = int'($urandom_range(0, sw + 10)) - 8;
                    y    = int'($urandom_range(0, sh + 10)) - 8;
                    rows = $urandom_range(0, h + 1);
                    n = w * h * $urandom_range(1, 3);
                    // sometimes stop mid-sprite so the next setting wraps the counters
                    if ($urandom_range(3) == 0) n += $urandom_range(1, w * h);
                end
            endcase
            write_reg(REG_SPRITE_X, 16'(x));
            write_reg(REG_SPRITE_Y, 16'(y));
            write_reg(REG_SPRITE_WIDTH, 16'(w));
            write_reg(REG_SPRITE_HEIGHT, 16'(h));
            write_reg(REG_ROWS_TO_DRAW, 16'(rows));
            write_reg(REG_SCREEN_WIDTH, 16'(sw));
            write_reg(REG_SCREEN_HEIGHT, 16'(sh));
            write_reg(REG_TRANSP_COLOR, key);
            i_cfg_we <= 1'b0;
            // fill the output stage now and then
            if (phase % 6 == 3) hold_req = 1'b1;
            repeat (n) send_pixel(($urandom_range(3) == 0) ? key : 16'($urandom));
            drain();
            phase++;
        end

        repeat (20) @(negedge i_clk);
        if (sb.errors == 0)
            $display("color_keyed_sprite_blit_unit test passed");
        else
            $display("color_keyed_sprite_blit_unit test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ckblit_pkg.sv
rtl/color_keyed_sprite_blit_unit.sv
test/color_keyed_sprite_blit_unit_tb.sv
